// ----- hdl/xts_pkg.sv -----
//------------------------------------------------------------------------------
// xts_pkg
// Shared codes, widths and types for the xor trie ordered set.
//------------------------------------------------------------------------------
`default_nettype none
package xts_pkg;
  localparam int KEY_BITS = 12;
  localparam int OP_W = 4;
  localparam int IN_KEY_W = KEY_BITS;
  localparam int KTH_W = 12;
  localparam int OUT_VAL_W = KEY_BITS;
  localparam int OUT_CNT_W = KEY_BITS + 1;

  localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 4'd1;
  localparam logic [OP_W-1:0] OP_HAS    = 4'd2;
  localparam logic [OP_W-1:0] OP_KTH    = 4'd3;
  localparam logic [OP_W-1:0] OP_POP    = 4'd4;
  localparam logic [OP_W-1:0] OP_RLT    = 4'd5;
  localparam logic [OP_W-1:0] OP_RLE    = 4'd6;
  localparam logic [OP_W-1:0] OP_MIN    = 4'd7;
  localparam logic [OP_W-1:0] OP_MAX    = 4'd8;
  localparam logic [OP_W-1:0] OP_GT     = 4'd9;
  localparam logic [OP_W-1:0] OP_LT     = 4'd10;
  localparam logic [OP_W-1:0] OP_GE     = 4'd11;
  localparam logic [OP_W-1:0] OP_LE     = 4'd12;
  localparam logic [OP_W-1:0] OP_XOR    = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [IN_KEY_W-1:0]  key;
    logic [KTH_W-1:0]     kth;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [OUT_VAL_W-1:0] value;
    logic [OUT_CNT_W-1:0] rank;
    logic [OUT_CNT_W-1:0] count;
  } rsp_t;
endpackage
`default_nettype wire

// ----- hdl/xts_if.sv -----
//------------------------------------------------------------------------------
// xts_if
// Valid/ready channel carrying one payload.
//------------------------------------------------------------------------------
`default_nettype none
interface xts_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/xor_trie_ordered_set.sv -----
//------------------------------------------------------------------------------
// xor_trie_ordered_set
// Ordered set of keys held as a tree of subtree counts, with a global xor.
//------------------------------------------------------------------------------
// Usage: requests (op, key, kth) arrive on in_ch, one result (ok, value, rank,
// count) leaves on out_ch per request. An item is transferred when valid and
// ready are both high. The block takes one request at a time; in_ch.ready
// is low from acceptance until the result has been transferred.
// A sequencer walks the count tree through one memory, a level at a time: a
// descent reads a child (S_DRD) and steps (S_DSTP) per level, an update of
// the path reads, waits and writes each node (S_URD, S_UWT, S_UWR) up to the
// root. Neighbor queries do a rank descent and then a select descent.
// After reset a clearing pass writes zero to all 2^(KEY_BITS+1) tree nodes,
// one per cycle, and no request is accepted during it. The result is held
// in an output register while the receiver stalls.
//------------------------------------------------------------------------------
`default_nettype none
module xor_trie_ordered_set (
  input wire logic clk,
  input wire logic rst_n,
  xts_if.sink      in_ch,
  xts_if.source    out_ch
);
  localparam int KEY_BITS = xts_pkg::KEY_BITS;
  localparam int AW = KEY_BITS + 1;
  localparam int LW = $clog2(KEY_BITS);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LEAF = 4'd2;
  localparam logic [3:0] S_LCHK = 4'd3;
  localparam logic [3:0] S_DRD  = 4'd4;
  localparam logic [3:0] S_DSTP = 4'd6;
  localparam logic [3:0] S_DEND = 4'd7;
  localparam logic [3:0] S_URD  = 4'd8;
  localparam logic [3:0] S_UWT  = 4'd9;
  localparam logic [3:0] S_UWR  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]          st_r, st_nxt;
  xts_pkg::req_t       req_r, req_nxt;
  logic [KEY_BITS-1:0] msk_r, msk_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       node_r, node_nxt;
  logic [AW-1:0]       acc_r, acc_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  logic [KEY_BITS-1:0] res_r, res_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic                sel_r, sel_nxt;
  logic                incl_r, incl_nxt;
  logic                up_r, up_nxt;
  logic                ok_r, ok_nxt;
  logic [AW-1:0]       rank_r, rank_nxt;
  xts_pkg::rsp_t       rsp_r, rsp_nxt;

  logic          we;
  logic [AW-1:0] waddr, wdata, raddr, rdata;

  xts_mem #(.AW(AW), .DW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [KEY_BITS-1:0] key_c;
  logic                mb, kb;
  logic [AW-1:0]       kth_c, child_m, child_o;
  logic                no_go;

  assign key_c   = req_r.key[KEY_BITS-1:0];
  assign mb      = msk_r[lvl_r];
  assign kb      = key_c[lvl_r];
  assign child_m = {node_r[AW-2:0], mb};
  assign child_o = {node_r[AW-2:0], ~mb};
  assign kth_c   = AW'(req_r.kth);
  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.data  = rsp_r;

  always_comb begin
    st_nxt = st_r; req_nxt = req_r; msk_nxt = msk_r; cnt_nxt = cnt_r;
    node_nxt = node_r; acc_nxt = acc_r; k_nxt = k_r; res_nxt = res_r;
    lvl_nxt = lvl_r; sel_nxt = sel_r; incl_nxt = incl_r; up_nxt = up_r;
    ok_nxt = ok_r; rank_nxt = rank_r; rsp_nxt = rsp_r;
    we = 1'b0; waddr = node_r; wdata = '0; raddr = node_r;
    no_go = 1'b0;
    unique case (st_r)
      S_CLR: begin
        we = 1'b1; waddr = node_r;
        node_nxt = node_r + 1'b1;
        if (node_r == '1) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ok_nxt = 1'b0; rank_nxt = '0; res_nxt = '0;
        if (in_ch.valid) begin
          req_nxt = in_ch.data;
          st_nxt = S_LEAF;
        end
      end
      S_LEAF: begin
        raddr = {1'b1, key_c ^ msk_r};
        node_nxt = {1'b1, key_c ^ msk_r};
        lvl_nxt = LW'(KEY_BITS - 1);
        acc_nxt = '0;
        unique case (req_r.op)
          xts_pkg::OP_ADD, xts_pkg::OP_REMOVE, xts_pkg::OP_HAS: begin
            st_nxt = S_LCHK;
          end
          xts_pkg::OP_KTH, xts_pkg::OP_POP: begin
            node_nxt = AW'(1); sel_nxt = 1'b1; k_nxt = kth_c;
            if (kth_c < cnt_r) begin
              st_nxt = S_DRD;
            end else begin
              st_nxt = S_DONE;
            end
          end
          xts_pkg::OP_MIN, xts_pkg::OP_MAX: begin
            node_nxt = AW'(1); sel_nxt = 1'b1;
            k_nxt = (req_r.op == xts_pkg::OP_MIN) ? '0 : cnt_r - 1'b1;
            st_nxt = (cnt_r != '0) ? S_DRD : S_DONE;
          end
          xts_pkg::OP_RLT, xts_pkg::OP_RLE, xts_pkg::OP_GT, xts_pkg::OP_LT,
          xts_pkg::OP_GE, xts_pkg::OP_LE: begin
            node_nxt = AW'(1); sel_nxt = 1'b0;
            incl_nxt = (req_r.op == xts_pkg::OP_RLE) || (req_r.op == xts_pkg::OP_GT)
                    || (req_r.op == xts_pkg::OP_LE);
            st_nxt = S_DRD;
          end
          xts_pkg::OP_XOR: begin
            msk_nxt = msk_r ^ key_c; ok_nxt = 1'b1; st_nxt = S_DONE;
          end
          default: begin
            st_nxt = S_DONE;
          end
        endcase
      end
      S_LCHK: begin
        priority if (req_r.op == xts_pkg::OP_HAS) begin
          ok_nxt = (rdata != '0); st_nxt = S_DONE;
        end else if (req_r.op == xts_pkg::OP_ADD) begin
          no_go = (rdata != '0);
          ok_nxt = !no_go; up_nxt = 1'b1;
          st_nxt = no_go ? S_DONE : S_URD;
        end else begin
          no_go = (rdata == '0);
          ok_nxt = !no_go; up_nxt = 1'b0;
          st_nxt = no_go ? S_DONE : S_URD;
        end
      end
      S_DRD: begin
        raddr = child_m; st_nxt = S_DSTP;
      end
      S_DSTP: begin
        if (sel_r) begin
          res_nxt = {res_r[KEY_BITS-2:0], !(k_r < rdata)};
          if (k_r < rdata) begin
            node_nxt = child_m;
          end else begin
            k_nxt = k_r - rdata; node_nxt = child_o;
          end
        end else begin
          if (kb) begin
            acc_nxt = acc_r + rdata; node_nxt = child_o;
          end else begin
            node_nxt = child_m;
          end
        end
        if (lvl_r == '0) begin
          st_nxt = S_DEND;
        end else begin
          lvl_nxt = lvl_r - 1'b1; st_nxt = S_DRD;
        end
      end
      S_DEND: begin
        // Leaf count is on rdata in the cycle after node_r settles; reread here.
        raddr = node_r;
        if (sel_r) begin
          ok_nxt = 1'b1;
          if (req_r.op == xts_pkg::OP_POP) begin
            up_nxt = 1'b0; st_nxt = S_URD;
          end else begin
            st_nxt = S_DONE;
          end
        end else begin
          st_nxt = S_URD; sel_nxt = 1'b1;
        end
      end
      S_URD: begin
        raddr = node_r;
        if (sel_r || req_r.op <= xts_pkg::OP_REMOVE) begin
          st_nxt = S_UWT;
        end else begin
          st_nxt = S_UWT;
        end
      end
      S_UWT: begin
        raddr = node_r;
        if (!sel_r && req_r.op > xts_pkg::OP_REMOVE) begin
          st_nxt = S_UWT;
        end
        if (req_r.op > xts_pkg::OP_POP) begin
          // Rank descent finished: fold in the leaf and pick the next step.
          acc_nxt = incl_r ? acc_r + rdata : acc_r;
          node_nxt = AW'(1); lvl_nxt = LW'(KEY_BITS - 1); res_nxt = '0;
          if (req_r.op == xts_pkg::OP_RLT || req_r.op == xts_pkg::OP_RLE) begin
            rank_nxt = incl_r ? acc_r + rdata : acc_r;
            ok_nxt = 1'b1; st_nxt = S_DONE;
          end else if (req_r.op == xts_pkg::OP_GT || req_r.op == xts_pkg::OP_GE) begin
            k_nxt = incl_r ? acc_r + rdata : acc_r;
            st_nxt = ((incl_r ? acc_r + rdata : acc_r) < cnt_r) ? S_DRD : S_DONE;
          end else begin
            k_nxt = (incl_r ? acc_r + rdata : acc_r) - 1'b1;
            st_nxt = ((incl_r ? acc_r + rdata : acc_r) != '0) ? S_DRD : S_DONE;
          end
        end else begin
          st_nxt = S_UWR;
        end
      end
      S_UWR: begin
        we = 1'b1; waddr = node_r;
        wdata = up_r ? rdata + 1'b1 : rdata - 1'b1;
        node_nxt = {1'b0, node_r[AW-1:1]};
        if (node_r == AW'(1)) begin
          cnt_nxt = wdata; st_nxt = S_DONE;
        end else begin
          st_nxt = S_URD;
        end
      end
      S_DONE: begin
        rsp_nxt.ok = ok_r;
        rsp_nxt.value = (ok_r && req_r.op >= xts_pkg::OP_KTH && req_r.op != xts_pkg::OP_RLT
                         && req_r.op != xts_pkg::OP_RLE && req_r.op != xts_pkg::OP_XOR)
                        ? xts_pkg::OUT_VAL_W'(res_r) : '0;
        rsp_nxt.rank = xts_pkg::OUT_CNT_W'(rank_r);
        rsp_nxt.count = xts_pkg::OUT_CNT_W'(cnt_r);
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; msk_r <= '0; cnt_r <= '0; node_r <= '0;
    end else begin
      st_r <= st_nxt; msk_r <= msk_nxt; cnt_r <= cnt_nxt; node_r <= node_nxt;
    end
    req_r <= req_nxt; acc_r <= acc_nxt; k_r <= k_nxt; res_r <= res_nxt;
    lvl_r <= lvl_nxt; sel_r <= sel_nxt; incl_r <= incl_nxt; up_r <= up_nxt;
    ok_r <= ok_nxt; rank_r <= rank_nxt; rsp_r <= rsp_nxt;
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("result dropped");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_CLR) |=> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1'b1
                      || cnt_r == $past(cnt_r) - 1'b1)) else $error("count jump");
`endif
endmodule
`default_nettype wire

// ----- hdl/xts_mem.sv -----
//------------------------------------------------------------------------------
// xts_mem
// Count tree storage: one write port and one registered read port.
//------------------------------------------------------------------------------
`default_nettype none
module xts_mem #(
  parameter int AW = 13,
  parameter int DW = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- tb/sv/xor_trie_ordered_set_tb.sv -----
//------------------------------------------------------------------------------
// xor_trie_ordered_set_tb
// Self-checking testbench for the xor trie ordered set. A directed table of
// requests covers the extremes, every operation and the failure cases, and is
// followed by random request streams. Every result is compared field by field
// with the output of a behavioral predictor that keeps its own count tree and
// mask. Both channels insert random idle bursts.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xor_trie_ordered_set_tb;
  localparam int KB = xts_pkg::KEY_BITS;
  localparam int NODES = 1 << (KB + 1);
  localparam int LEAF0 = 1 << KB;
  localparam int N_RAND = 900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  xts_if #(.T(xts_pkg::req_t)) in_ch ();
  xts_if #(.T(xts_pkg::rsp_t)) out_ch ();

  xor_trie_ordered_set dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  typedef struct {
    xts_pkg::req_t req;
    logic          fixed;
    xts_pkg::rsp_t rsp;
  } row_t;

  int            tree_cnt [NODES];
  logic [KB-1:0] set_mask;
  xts_pkg::rsp_t want_q [$];
  int            errors = 0;
  bit            calm = 0;
  row_t          rows [$];

  function automatic int rank_below(logic [KB-1:0] x, bit incl);
    int n, r;
    n = 1;
    r = 0;
    for (int i = KB - 1; i >= 0; i--) begin
      if (x[i]) begin
        r += tree_cnt[2 * n + set_mask[i]];
        n = 2 * n + (set_mask[i] ^ 1);
      end else begin
        n = 2 * n + set_mask[i];
      end
    end
    if (incl) r += tree_cnt[n];
    return r;
  endfunction

  function automatic logic [KB-1:0] select_at(int k, output int leaf);
    int n, t;
    logic [KB-1:0] res;
    n = 1;
    res = '0;
    for (int i = KB - 1; i >= 0; i--) begin
      t = tree_cnt[2 * n + set_mask[i]];
      if (k < t) begin
        res[i] = 1'b0;
        n = 2 * n + set_mask[i];
      end else begin
        k -= t;
        res[i] = 1'b1;
        n = 2 * n + (set_mask[i] ^ 1);
      end
    end
    leaf = n;
    return res;
  endfunction

  function automatic void walk_path(int leaf, int d);
    for (int n = leaf; n >= 1; n = n >> 1) tree_cnt[n] += d;
  endfunction

  function automatic xts_pkg::rsp_t set_op_result(xts_pkg::req_t q);
    xts_pkg::rsp_t o;
    int leaf, lf, cnt, r, rk, cnt_after;
    o = '0;
    leaf = LEAF0 + int'(q.key ^ set_mask);
    cnt = tree_cnt[1];
    case (q.op)
      xts_pkg::OP_ADD: if (tree_cnt[leaf] == 0) begin
        walk_path(leaf, 1);
        o.ok = 1;
      end
      xts_pkg::OP_REMOVE: if (tree_cnt[leaf] != 0) begin
        walk_path(leaf, -1);
        o.ok = 1;
      end
      xts_pkg::OP_HAS: o.ok = tree_cnt[leaf] != 0;
      xts_pkg::OP_KTH, xts_pkg::OP_POP: if (int'(q.kth) < cnt) begin
        o.value = select_at(int'(q.kth), lf);
        if (q.op == xts_pkg::OP_POP) walk_path(lf, -1);
        o.ok = 1;
      end
      xts_pkg::OP_RLT, xts_pkg::OP_RLE: begin
        rk = rank_below(q.key, q.op == xts_pkg::OP_RLE);
        o.rank = rk[xts_pkg::OUT_CNT_W-1:0];
        o.ok = 1;
      end
      xts_pkg::OP_MIN, xts_pkg::OP_MAX: if (cnt != 0) begin
        o.value = select_at(q.op == xts_pkg::OP_MIN ? 0 : cnt - 1, lf);
        o.ok = 1;
      end
      xts_pkg::OP_GT, xts_pkg::OP_GE: begin
        r = rank_below(q.key, q.op == xts_pkg::OP_GT);
        if (r < cnt) begin
          o.value = select_at(r, lf);
          o.ok = 1;
        end
      end
      xts_pkg::OP_LT, xts_pkg::OP_LE: begin
        r = rank_below(q.key, q.op == xts_pkg::OP_LE);
        if (r > 0) begin
          o.value = select_at(r - 1, lf);
          o.ok = 1;
        end
      end
      xts_pkg::OP_XOR: begin
        set_mask ^= q.key;
        o.ok = 1;
      end
      default: ;
    endcase
    cnt_after = tree_cnt[1];
    o.count = cnt_after[xts_pkg::OUT_CNT_W-1:0];
    return o;
  endfunction

  function automatic xts_pkg::req_t mk(logic [3:0] op, int key, int kth);
    xts_pkg::req_t q;
    q.op = op;
    q.key = key[xts_pkg::IN_KEY_W-1:0];
    q.kth = kth[xts_pkg::KTH_W-1:0];
    return q;
  endfunction

  function automatic void add_row(logic [3:0] op, int key, int kth, bit fx,
                                  bit ok = 0, int val = 0, int rk = 0, int cnt = 0);
    row_t r;
    r.req = mk(op, key, kth);
    r.fixed = fx;
    r.rsp.ok = ok;
    r.rsp.value = val[xts_pkg::OUT_VAL_W-1:0];
    r.rsp.rank = rk[xts_pkg::OUT_CNT_W-1:0];
    r.rsp.count = cnt[xts_pkg::OUT_CNT_W-1:0];
    rows.push_back(r);
  endfunction

  task automatic send(xts_pkg::req_t q, bit fx, xts_pkg::rsp_t fixed_rsp);
    xts_pkg::rsp_t p;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = set_op_result(q);
    if (fx && p !== fixed_rsp) begin
      errors++;
      if (errors <= 10)
        $display("table mismatch op=%0d: table %p, predictor %p", q.op, fixed_rsp, p);
    end
    want_q.push_back(p);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_req(int key_pool);
    int k, c;
    logic [3:0] op;
    c = tree_cnt[1];
    k = key_pool == 0 ? $urandom_range(0, 4095) : $urandom_range(0, key_pool);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: op = xts_pkg::OP_ADD;
      5, 6: op = xts_pkg::OP_REMOVE;
      7: op = xts_pkg::OP_HAS;
      8: op = xts_pkg::OP_KTH;
      9: op = xts_pkg::OP_POP;
      10: op = xts_pkg::OP_RLT;
      11: op = xts_pkg::OP_RLE;
      12: op = xts_pkg::OP_MIN;
      13: op = xts_pkg::OP_MAX;
      14: op = xts_pkg::OP_GT;
      15: op = xts_pkg::OP_LT;
      16: op = xts_pkg::OP_GE;
      17: op = xts_pkg::OP_LE;
      18: op = xts_pkg::OP_XOR;
      default: op = 4'($urandom_range(0, 15));
    endcase
    send(mk(op, k, $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                             : $urandom_range(0, c + 1)),
         0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 10) - 1) @(posedge clk);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    xts_pkg::rsp_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_ch.data);
      end else begin
        w = want_q.pop_front();
        if (out_ch.data.ok !== w.ok || out_ch.data.value !== w.value ||
            out_ch.data.rank !== w.rank || out_ch.data.count !== w.count) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected ok=%0d value=%0d rank=%0d count=%0d, ",
                      "got ok=%0d value=%0d rank=%0d count=%0d"},
                     w.ok, w.value, w.rank, w.count, out_ch.data.ok,
                     out_ch.data.value, out_ch.data.rank, out_ch.data.count);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    set_mask = '0;
    foreach (tree_cnt[i]) tree_cnt[i] = 0;
    // Empty set: lookups fail, rank queries succeed with zero.
    add_row(xts_pkg::OP_MIN, 0, 0, 1, 0, 0, 0, 0);
    add_row(xts_pkg::OP_MAX, 0, 0, 1, 0, 0, 0, 0);
    add_row(xts_pkg::OP_KTH, 0, 0, 1, 0, 0, 0, 0);
    add_row(xts_pkg::OP_POP, 0, 4095, 1, 0, 0, 0, 0);
    add_row(xts_pkg::OP_RLE, 4095, 0, 1, 1, 0, 0, 0);
    add_row(xts_pkg::OP_REMOVE, 7, 0, 1, 0, 0, 0, 0);
    add_row(xts_pkg::OP_ADD, 0, 0, 1, 1, 0, 0, 1);
    add_row(xts_pkg::OP_ADD, 4095, 0, 1, 1, 0, 0, 2);
    add_row(xts_pkg::OP_ADD, 4095, 0, 1, 0, 0, 0, 2);
    add_row(xts_pkg::OP_HAS, 4095, 0, 1, 1, 0, 0, 2);
    add_row(xts_pkg::OP_MAX, 0, 0, 1, 1, 4095, 0, 2);
    add_row(xts_pkg::OP_KTH, 0, 2, 1, 0, 0, 0, 2);
    add_row(xts_pkg::OP_ADD, 1234, 0, 0);
    add_row(xts_pkg::OP_RLT, 1234, 0, 0);
    add_row(xts_pkg::OP_RLE, 1234, 0, 0);
    add_row(xts_pkg::OP_GT, 4095, 0, 0);
    add_row(xts_pkg::OP_LT, 0, 0, 0);
    add_row(xts_pkg::OP_GE, 1000, 0, 0);
    add_row(xts_pkg::OP_LE, 2000, 0, 0);
    add_row(xts_pkg::OP_XOR, 2730, 0, 0);
    add_row(xts_pkg::OP_MIN, 0, 0, 0);
    add_row(xts_pkg::OP_POP, 0, 1, 0);
    add_row(xts_pkg::OP_KTH, 0, 4095, 0);
    add_row(4'd14, 5, 0, 0);
    add_row(4'd15, 4095, 4095, 0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send(rows[i].req, rows[i].fixed, rows[i].rsp);
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND / 3) begin
        while (want_q.size() != 0) @(posedge clk);
      end
      if (i == N_RAND * 4 / 5) calm = 1;
      random_req(i < N_RAND / 2 ? 63 : 0);
    end
    while (want_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/xts_pkg.sv
hdl/xts_if.sv
hdl/xts_mem.sv
hdl/xor_trie_ordered_set.sv
tb/sv/xor_trie_ordered_set_tb.sv
